@@ rtl/egcd_pkg.sv @@
`timescale 1ns / 1ps

package egcd_pkg;

    // Control word from the sequencer to the shared division/accumulate unit
    typedef struct packed {
        logic clear;    // start a new quotient: zero remainder and products
        logic advance;  // take one dividend bit, resolve one quotient bit
    } t_step_ctrl;

endpackage

@@ rtl/egcd_step_unit.sv @@
`timescale 1ns / 1ps

// One restoring-division step per cycle while advance is set. Alongside the
// remainder, it builds q*s1 and q*t1 MSB first, modulo 2^DATA_WIDTH.
module egcd_step_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  egcd_pkg::t_step_ctrl  i_ctrl,
    input  logic                  i_dividend_bit,
    input  logic [DATA_WIDTH-2:0] i_divisor,
    input  logic [DATA_WIDTH-1:0] i_coeff_s,
    input  logic [DATA_WIDTH-1:0] i_coeff_t,
    output logic [DATA_WIDTH-2:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_prod_s,
    output logic [DATA_WIDTH-1:0] o_prod_t
);

    localparam int OW = DATA_WIDTH - 1;

    logic [OW-1:0]         r_rem;
    logic [DATA_WIDTH-1:0] r_prod_s;
    logic [DATA_WIDTH-1:0] r_prod_t;

    logic [OW:0]           shifted;
    logic                  q_bit;
    logic [OW:0]           diff;

    assign shifted = {r_rem, i_dividend_bit};
    assign q_bit   = (shifted >= {1'b0, i_divisor});
    assign diff    = shifted - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_rem    <= '0;
            r_prod_s <= '0;
            r_prod_t <= '0;
        end else if (i_ctrl.advance) begin
            r_rem    <= q_bit ? diff[OW-1:0] : shifted[OW-1:0];
            r_prod_s <= {r_prod_s[DATA_WIDTH-2:0], 1'b0} + (q_bit ? i_coeff_s : '0);
            r_prod_t <= {r_prod_t[DATA_WIDTH-2:0], 1'b0} + (q_bit ? i_coeff_t : '0);
        end
    end

    assign o_rem    = r_rem;
    assign o_prod_s = r_prod_s;
    assign o_prod_t = r_prod_t;

    // Partial remainder must stay below the divisor after every step
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.advance && !i_ctrl.clear |=> r_rem < $past(i_divisor))
        else $error("partial remainder not below divisor");

    // Clear and advance are never issued together
    a_ctrl_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.advance && i_ctrl.clear))
        else $error("clear and advance in the same cycle");

    // A clear leaves a zero remainder for the first step
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> r_rem == '0)
        else $error("remainder not zero after clear");

endmodule

@@ rtl/extended_gcd_inverse_core.sv @@
`timescale 1ns / 1ps

// Extended Euclidean core: for operands a and b it returns d = gcd(a, b), Bezout
// coefficients u and v with u*a + v*b = d, and u reduced modulo b (u, plus b
// when u is negative), which is the inverse of a mod b whenever d is 1 (not
// checked). b = 0 gives d = a, u = 1, v = 0. One transfer in, one transfer out;
// the input is not ready while an item is being worked on. Each Euclid
// iteration passes through a check state, the one-bit-per-cycle restoring
// divider (which also builds q*s and q*t bit by bit), taking one step per
// dividend bit, and an update state. The result sits in an output register,
// so the next item is taken while it waits for its transfer.
module extended_gcd_inverse_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DATA_WIDTH-2:0] i_first_value,
    input  logic [DATA_WIDTH-2:0] i_second_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-2:0] o_gcd_value,
    output logic [DATA_WIDTH-1:0] o_coeff_first,
    output logic [DATA_WIDTH-1:0] o_coeff_second,
    output logic [DATA_WIDTH-2:0] o_inverse_value
);

    localparam int OW = DATA_WIDTH - 1;
    localparam int CW = $clog2(OW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_cnt;
    logic [OW-1:0]         r_r0;      // dividend, shifted out MSB first while dividing
    logic [OW-1:0]         r_r1;      // divisor
    logic [OW-1:0]         r_b;       // original modulus, kept for the reduction
    logic [DATA_WIDTH-1:0] r_s0;
    logic [DATA_WIDTH-1:0] r_s1;
    logic [DATA_WIDTH-1:0] r_t0;
    logic [DATA_WIDTH-1:0] r_t1;
    logic                  r_out_valid;
    logic [OW-1:0]         r_gcd;
    logic [DATA_WIDTH-1:0] r_coeff_s;
    logic [DATA_WIDTH-1:0] r_coeff_t;
    logic [OW-1:0]         r_inv;

    egcd_pkg::t_step_ctrl  step_ctrl;
    logic [OW-1:0]         unit_rem;
    logic [DATA_WIDTH-1:0] unit_prod_s;
    logic [DATA_WIDTH-1:0] unit_prod_t;
    logic [DATA_WIDTH-1:0] inv_sum;
    logic                  in_xfer;
    logic                  out_free;

    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Clear the unit on entry to a division, advance it once per dividend bit
    always_comb begin
        step_ctrl.clear   = (r_state == ST_CHECK) && (r_r1 != '0);
        step_ctrl.advance = (r_state == ST_DIV);
    end

    egcd_step_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (step_ctrl),
        .i_dividend_bit (r_r0[OW-1]),
        .i_divisor      (r_r1),
        .i_coeff_s      (r_s1),
        .i_coeff_t      (r_t1),
        .o_rem          (unit_rem),
        .o_prod_s       (unit_prod_s),
        .o_prod_t       (unit_prod_t)
    );

    // Reduce u into range by adding the modulus when it is negative
    assign inv_sum = r_s0 + DATA_WIDTH'(r_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once it has been transferred; in the finish state
            // the new result takes its place instead
            if (r_out_valid && i_ready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_r0    <= i_first_value;
                        r_r1    <= i_second_value;
                        r_b     <= i_second_value;
                        r_s0    <= DATA_WIDTH'(1);
                        r_s1    <= '0;
                        r_t0    <= '0;
                        r_t1    <= DATA_WIDTH'(1);
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    // A zero divisor ends the loop; r0, s0, t0 hold the answer
                    if (r_r1 == '0) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_cnt   <= CW'(OW - 1);
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_r0 <= {r_r0[OW-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    // Advance the remainder and coefficient pairs by one step
                    r_r0    <= r_r1;
                    r_r1    <= unit_rem;
                    r_s0    <= r_s1;
                    r_s1    <= r_s0 - unit_prod_s;
                    r_t0    <= r_t1;
                    r_t1    <= r_t0 - unit_prod_t;
                    r_state <= ST_CHECK;
                end
                ST_FINISH: begin
                    // Hold here until the output register is free
                    if (out_free) begin
                        r_gcd       <= r_r0;
                        r_coeff_s   <= r_s0;
                        r_coeff_t   <= r_t0;
                        r_inv       <= r_s0[DATA_WIDTH-1] ? inv_sum[OW-1:0] : r_s0[OW-1:0];
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_gcd_value     = r_gcd;
    assign o_coeff_first   = r_coeff_s;
    assign o_coeff_second  = r_coeff_t;
    assign o_inverse_value = r_inv;

    // An accepted item keeps the input closed on the next cycle
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_ready)
        else $error("input ready straight after a transfer");

    // The divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_r1 != '0)
        else $error("division step with zero divisor");

    // The loop only finishes once the remainder has reached zero
    a_finish_on_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINISH |-> r_r1 == '0)
        else $error("finished with non-zero remainder");

    // A waiting result is never overwritten before its transfer
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINISH && r_out_valid && !i_ready |=> r_state == ST_FINISH)
        else $error("result written over a pending one");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Drive operand pairs into the extended Euclid core and check every result
// transfer against the Bezout solver below or the result typed into its row.
// Each item gives exactly one result, so expectations queue in input order.
module tb_top;

    localparam int W          = 32;             // DATA_WIDTH of the core
    localparam int RANDOM_OPS = 380;
    localparam int CALM_FROM  = 330;            // no idling from this random item on
    localparam int DRAIN_WAIT = 1600;           // a little over the longest item
    localparam int IDLE_LIMIT = 20000;          // cycles without any transfer

    localparam logic [W-2:0] MAXV  = '1;
    localparam logic [W-2:0] FIB45 = 31'd1134903170;
    localparam logic [W-2:0] FIB46 = 31'd1836311903;

    typedef struct packed {
        logic [W-2:0] gcd;
        logic [W-1:0] u;
        logic [W-1:0] v;
        logic [W-2:0] inv;
    } t_egcd_result;

    typedef struct packed {
        logic [W-2:0]  a;
        logic [W-2:0]  b;
        logic          typed;   // expected result written into the row
        t_egcd_result  want;
    } t_operand_row;

    logic         i_clk          = 1'b0;
    logic         i_rst_n        = 1'b0;
    logic         i_valid        = 1'b0;
    logic         o_ready;
    logic [W-2:0] i_first_value  = '0;
    logic [W-2:0] i_second_value = '0;
    logic         o_valid;
    logic         i_ready        = 1'b0;
    logic [W-2:0] o_gcd_value;
    logic [W-1:0] o_coeff_first;
    logic [W-1:0] o_coeff_second;
    logic [W-2:0] o_inverse_value;

    // Row currently on the input port; held with the payload until its transfer
    logic         row_typed = 1'b0;
    t_egcd_result row_want  = '0;

    t_egcd_result bezout_results[$];
    t_operand_row directed_rows[$];
    int           fail_count = 0;
    int           idle_cycles = 0;
    int           ready_left = 0;
    bit           calm = 1'b0;

    extended_gcd_inverse_core #(
        .DATA_WIDTH(W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_gcd_value    (o_gcd_value),
        .o_coeff_first  (o_coeff_first),
        .o_coeff_second (o_coeff_second),
        .o_inverse_value(o_inverse_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Iterative extended Euclid with truncating quotients. Coefficients live in
    // 64 bits of two's complement, which is exact for 31-bit operands.
    function automatic t_egcd_result solve_bezout(input logic [W-2:0] a,
                                                  input logic [W-2:0] b);
        logic [63:0]  r_prev, r_cur, s_prev, s_cur, t_prev, t_cur;
        logic [63:0]  quot, r_next, s_next, t_next, reduced;
        t_egcd_result res;
        r_prev = 64'(a);
        r_cur  = 64'(b);
        s_prev = 64'd1;
        s_cur  = 64'd0;
        t_prev = 64'd0;
        t_cur  = 64'd1;
        while (r_cur != 64'd0) begin
            quot   = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            s_next = s_prev - quot * s_cur;
            t_next = t_prev - quot * t_cur;
            r_prev = r_cur;
            r_cur  = r_next;
            s_prev = s_cur;
            s_cur  = s_next;
            t_prev = t_cur;
            t_cur  = t_next;
        end
        // fold a negative u back into range by adding the modulus once
        reduced = s_prev[63] ? s_prev + 64'(b) : s_prev;
        res.gcd = r_prev[W-2:0];
        res.u   = s_prev[W-1:0];
        res.v   = t_prev[W-1:0];
        res.inv = reduced[W-2:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t ns", what, got, want,
                 $time);
        fail_count++;
    endtask

    task automatic table_row(input logic [W-2:0] a, input logic [W-2:0] b,
                             input logic typed, input logic [W-2:0] gcd,
                             input logic [W-1:0] u, input logic [W-1:0] v,
                             input logic [W-2:0] inv);
        t_operand_row row;
        row.a        = a;
        row.b        = b;
        row.typed    = typed;
        row.want.gcd = gcd;
        row.want.u   = u;
        row.want.v   = v;
        row.want.inv = inv;
        directed_rows.push_back(row);
    endtask

    // Offer one operand pair and hold it until the transfer. Called just after a
    // falling edge; returns just after the falling edge that follows the transfer,
    // so a back-to-back item keeps valid high without lowering it.
    task automatic transfer_operands(input t_operand_row row);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap     = $urandom_range(1, 18);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_first_value  = row.a;
        i_second_value = row.b;
        row_typed      = row.typed;
        row_want       = row.want;
        i_valid        = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Result side: stall in random bursts between runs of readiness,
    // and hold ready high once the calm stretch begins.
    always @(negedge i_clk) begin
        if (calm) begin
            i_ready <= 1'b1;
        end else if (ready_left == 0) begin
            if (i_ready && $urandom_range(0, 2) == 0) begin
                i_ready    <= 1'b0;
                ready_left <= $urandom_range(1, 18);
            end else begin
                i_ready    <= 1'b1;
                ready_left <= $urandom_range(0, 40);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // Sample both channels at the rising edge: check the result transfer against
    // the oldest expectation first, then queue the expectation for a new input.
    always @(posedge i_clk) begin : monitor_p
        t_egcd_result head;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (bezout_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding",
                                    64'(o_gcd_value), 64'd0);
                end else begin
                    head = bezout_results.pop_front();
                    if (o_gcd_value !== head.gcd)
                        report_mismatch("gcd_value", 64'(o_gcd_value), 64'(head.gcd));
                    if (o_coeff_first !== head.u)
                        report_mismatch("coeff_first", 64'(o_coeff_first), 64'(head.u));
                    if (o_coeff_second !== head.v)
                        report_mismatch("coeff_second", 64'(o_coeff_second),
                                        64'(head.v));
                    if (o_inverse_value !== head.inv)
                        report_mismatch("inverse_value", 64'(o_inverse_value),
                                        64'(head.inv));
                end
            end
            if (i_valid && o_ready) begin
                bezout_results.push_back(row_typed ? row_want
                                                   : solve_bezout(i_first_value,
                                                                  i_second_value));
            end
        end
        // the watchdog only advances while neither side moves a transfer
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog_p
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin : stimulus_p
        int           n;
        int           kind;
        int           factor;
        t_operand_row row;

        // Zero modulus, both zero, zero first operand: results fixed by definition
        table_row('0, '0, 1'b1, '0, 32'd1, 32'd0, 31'd1);
        table_row(31'd5, '0, 1'b1, 31'd5, 32'd1, 32'd0, 31'd1);
        table_row(MAXV, '0, 1'b1, MAXV, 32'd1, 32'd0, 31'd1);
        table_row('0, 31'd7, 1'b1, 31'd7, 32'd0, 32'd1, '0);
        table_row('0, MAXV, 1'b1, MAXV, 32'd0, 32'd1, '0);
        // 3 * 5 = 15 = 1 mod 7, with u negative before the fold
        table_row(31'd3, 31'd7, 1'b1, 31'd1, -32'sd2, 32'd1, 31'd5);
        // extremes, gcd other than one, and the longest quotient chains
        table_row(31'd1, 31'd1, 1'b0, '0, '0, '0, '0);
        table_row(MAXV, MAXV, 1'b0, '0, '0, '0, '0);
        table_row(31'd1, MAXV, 1'b0, '0, '0, '0, '0);
        table_row(MAXV, 31'd1, 1'b0, '0, '0, '0, '0);
        table_row(31'd2, MAXV, 1'b0, '0, '0, '0, '0);
        table_row(MAXV, MAXV - 31'd1, 1'b0, '0, '0, '0, '0);
        table_row(31'd12, 31'd18, 1'b0, '0, '0, '0, '0);
        table_row(31'd18, 31'd12, 1'b0, '0, '0, '0, '0);
        table_row(31'd2, 31'd4, 1'b0, '0, '0, '0, '0);
        table_row(31'd1000000000, 31'd2000000000, 1'b0, '0, '0, '0, '0);
        table_row(FIB46, FIB45, 1'b0, '0, '0, '0, '0);
        table_row(FIB45, FIB46, 1'b0, '0, '0, '0, '0);
        table_row(31'h2AAAAAAA, 31'h55555555, 1'b0, '0, '0, '0, '0);
        table_row(31'h40000000, 31'd3, 1'b0, '0, '0, '0, '0);
        table_row(31'd240, 31'd46, 1'b0, '0, '0, '0, '0);
        table_row(31'd17, 31'd3120, 1'b0, '0, '0, '0, '0);

        // hold reset, then release it away from the rising edge
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            transfer_operands(directed_rows[i]);

        row = '0;
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n == CALM_FROM)
                calm = 1'b1;
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    row.a = 31'($urandom);
                    row.b = 31'($urandom);
                end
                4, 5: begin
                    // small operands: short runs, quick result turnaround
                    row.a = 31'($urandom_range(0, 40));
                    row.b = 31'($urandom_range(0, 40));
                end
                6: begin
                    if ($urandom_range(0, 1) == 0) begin
                        row.a = 31'($urandom);
                        row.b = '0;
                    end else begin
                        row.a = '0;
                        row.b = 31'($urandom);
                    end
                end
                7: begin
                    // shared factor, so the gcd is never one
                    factor = $urandom_range(2, 1000);
                    row.a  = 31'(factor * $urandom_range(0, 2000000));
                    row.b  = 31'(factor * $urandom_range(0, 2000000));
                end
                8: begin
                    row.a = 31'($urandom);
                    row.b = row.a ^ (31'd1 << $urandom_range(0, 30));
                end
                default: begin
                    row.a = 31'(MAXV - $urandom_range(0, 3));
                    row.b = $urandom_range(0, 1) ? 31'(MAXV - $urandom_range(0, 3))
                                                 : 31'($urandom);
                end
            endcase
            transfer_operands(row);
        end
        i_valid = 1'b0;

        // drain every outstanding result, then watch for strays
        while (bezout_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
